/* src/kmrd_pkg.sv */
// ----------------------------------------------------------------------------
// kmrd_pkg
// Shared widths, constants and the bit-count helper for the key matrix row
// debouncer.
// ----------------------------------------------------------------------------
package kmrd_pkg;

    localparam int ROW_IDX_W   = 4;
    localparam int SAMPLE_W    = 8;
    localparam int COUNT_W     = 8;
    localparam int MAX_COLUMNS = 16;
    localparam int BITCNT_W    = 5;

    localparam int S_FIELDS_W  = ROW_IDX_W + SAMPLE_W;
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W  = ROW_IDX_W + SAMPLE_W + SAMPLE_W + 1 + COUNT_W;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef logic [MAX_COLUMNS-1:0] col_word_t;
    typedef logic [BITCNT_W-1:0]    bit_cnt_t;

    function automatic bit_cnt_t count_ones(col_word_t v);
        bit_cnt_t n;
        n = '0;
        for (int i = 0; i < MAX_COLUMNS; i++) begin
            n = n + bit_cnt_t'(v[i]);
        end
        return n;
    endfunction

endpackage

/* src/key_matrix_row_debouncer_unit.sv */
// ----------------------------------------------------------------------------
// key_matrix_row_debouncer_unit
// Debounces scanned key matrix rows with per-row lockout shadow masks and
// keeps a running pressed-key count.
// ----------------------------------------------------------------------------
//  channel | tdata fields (low bit up)                         | tlast
//  s_      | row_index[3:0] column_sample[11:4]                | end_of_scan
//  m_      | row_number[3:0] debounced_row[11:4]               | -
//          | accepted_changes[19:12] scan_changed[20]          |
//          | pressed_count[28:21]                              |
//
//  One beat per cycle unless a held result stalls; it shows the cycle after.
//  Matrix, shadows and count update in the accept cycle, so the next row
//  sees them immediately. The output register frees when m_tready is high.
//  aresetn (sync, active low) clears matrix, shadows, scan flag and count.
// ----------------------------------------------------------------------------
module key_matrix_row_debouncer_unit #(
    parameter int ROW_COUNT      = 16,
    parameter int COLUMN_COUNT   = 8,
    parameter int DEBOUNCE_DEPTH = 3
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // row_index[3:0], column_sample[11:4]
    input  logic [kmrd_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // row_number[3:0], debounced_row[11:4], accepted_changes[19:12],
    // scan_changed[20], pressed_count[28:21]
    output logic [kmrd_pkg::M_TDATA_W-1:0] m_tdata
);
    import kmrd_pkg::*;

    localparam int RowIdxW  = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int ColW     = COLUMN_COUNT;
    localparam int TotalW   = $clog2(ROW_COUNT * COLUMN_COUNT + 1);
    localparam int TotExtW  = TotalW + COUNT_W;
    localparam int MPadW    = M_TDATA_W - M_FIELDS_W;

    typedef logic [ColW-1:0] row_bits_t;

    row_bits_t                 matrix_reg [ROW_COUNT];
    row_bits_t                 matrix_next[ROW_COUNT];
    row_bits_t                 shadow_reg [DEBOUNCE_DEPTH][ROW_COUNT];
    row_bits_t                 shadow_next[DEBOUNCE_DEPTH][ROW_COUNT];
    logic                      changed_reg, changed_next;
    logic [TotalW-1:0]         total_reg, total_next;
    logic                      m_tvalid_reg;
    logic [M_TDATA_W-1:0]      m_tdata_reg, m_tdata_next;

    logic                      in_beat;
    logic [ROW_IDX_W-1:0]      in_row;
    logic [SAMPLE_W-1:0]       in_sample;
    logic [ColW+SAMPLE_W-1:0]  sample_ext;
    row_bits_t                 sample;
    logic [RowIdxW+ROW_IDX_W-1:0] row_ext;
    logic [RowIdxW-1:0]        row_sel;
    logic                      row_ok;
    row_bits_t                 cur_row, lock, changes, new_row;
    logic [MAX_COLUMNS+ColW-1:0] rise_ext, fall_ext;
    bit_cnt_t                  rise_cnt, fall_cnt;
    logic [TotExtW-1:0]        tot_ext;
    logic [COUNT_W-1:0]        pressed_out;
    logic [ColW+SAMPLE_W-1:0]  row_out_ext, chg_out_ext;
    logic                      scan_out;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_beat  = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign in_row     = s_tdata[ROW_IDX_W-1:0];
    assign in_sample  = s_tdata[ROW_IDX_W +: SAMPLE_W];
    assign sample_ext = {{ColW{1'b0}}, in_sample};
    assign sample     = sample_ext[ColW-1:0];
    assign row_ext    = {{RowIdxW{1'b0}}, in_row};
    assign row_sel    = row_ext[RowIdxW-1:0];
    assign row_ok     = int'(in_row) < ROW_COUNT;

    // rows past the matrix change nothing and report zero row and change bits
    assign cur_row = row_ok ? matrix_reg[row_sel]    : '0;
    assign lock    = row_ok ? shadow_reg[0][row_sel] : '0;
    assign changes = row_ok ? ((cur_row ^ sample) & ~lock) : '0;
    assign new_row = cur_row ^ changes;

    assign rise_ext = {{MAX_COLUMNS{1'b0}}, changes & sample};
    assign fall_ext = {{MAX_COLUMNS{1'b0}}, changes & ~sample};
    assign rise_cnt = count_ones(rise_ext[MAX_COLUMNS-1:0]);
    assign fall_cnt = count_ones(fall_ext[MAX_COLUMNS-1:0]);

    assign total_next  = total_reg + TotalW'(rise_cnt) - TotalW'(fall_cnt);
    assign tot_ext     = {{COUNT_W{1'b0}}, total_next};
    assign pressed_out = (tot_ext > TotExtW'(COUNT_MAX)) ? COUNT_MAX
                                                         : tot_ext[COUNT_W-1:0];

    assign row_out_ext  = {{SAMPLE_W{1'b0}}, new_row};
    assign chg_out_ext  = {{SAMPLE_W{1'b0}}, changes};
    assign scan_out     = changed_reg || (|changes);
    assign changed_next = s_tlast ? 1'b0 : scan_out;
    assign m_tdata_next = {{MPadW{1'b0}}, pressed_out, scan_out,
                           chg_out_ext[SAMPLE_W-1:0], row_out_ext[SAMPLE_W-1:0],
                           in_row};

    always_comb begin
        row_bits_t upd[DEBOUNCE_DEPTH][ROW_COUNT];
        for (int r = 0; r < ROW_COUNT; r++) begin
            matrix_next[r] = (row_ok && (RowIdxW'(r) == row_sel)) ? new_row
                                                                 : matrix_reg[r];
            for (int d = 0; d < DEBOUNCE_DEPTH; d++) begin
                upd[d][r] = shadow_reg[d][r] |
                            ((row_ok && (RowIdxW'(r) == row_sel)) ? changes : '0);
            end
        end
        for (int d = 0; d < DEBOUNCE_DEPTH; d++) begin
            for (int r = 0; r < ROW_COUNT; r++) begin
                if (!s_tlast) begin
                    shadow_next[d][r] = upd[d][r];
                end else if (d + 1 < DEBOUNCE_DEPTH) begin
                    shadow_next[d][r] = upd[(d + 1) % DEBOUNCE_DEPTH][r];
                end else begin
                    shadow_next[d][r] = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            changed_reg  <= 1'b0;
            total_reg    <= '0;
            for (int r = 0; r < ROW_COUNT; r++) begin
                matrix_reg[r] <= '0;
                for (int d = 0; d < DEBOUNCE_DEPTH; d++) begin
                    shadow_reg[d][r] <= '0;
                end
            end
        end else begin
            if (in_beat) begin
                m_tvalid_reg <= 1'b1;
                changed_reg  <= changed_next;
                total_reg    <= total_next;
                matrix_reg   <= matrix_next;
                shadow_reg   <= shadow_next;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_beat) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

`ifndef SYNTHESIS
    a_change_flags_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[ROW_IDX_W+SAMPLE_W +: SAMPLE_W] != '0)
        |-> m_tdata[ROW_IDX_W+2*SAMPLE_W])
        else $error("accepted changes without scan_changed");

    a_scan_flag_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat && s_tlast |=> !changed_reg)
        else $error("scan flag not cleared after end of scan");

    a_stall_holds_out: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid_reg && !m_tready)
        else $error("input stalled without a pending result");

    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(total_reg) <= ROW_COUNT * COLUMN_COUNT)
        else $error("key total exceeds matrix size");
`endif

endmodule
